// ===== rtl/core/bcpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared types, constants and the binomial table for the Bezier curve point
// evaluator: payload structs, sequencer states, multiplier operations.
// ----------------------------------------------------------------------------
package bcpe_pkg;

	// Field widths
	localparam int COORD_W = 32;
	localparam int T_W     = 17;
	localparam int DEG_W   = 3;
	localparam int POW_W   = 31;  // Q2.30 power of t or (1-t), at most 2^30
	localparam int Q_W     = 29;  // Q.28 weight, at most 2^28
	localparam int BIN_W   = 6;   // C(7,3) = 35 is the largest coefficient
	localparam int OPND_W  = 33;  // signed multiplier operand
	localparam int PROD_W  = 66;  // signed multiplier product
	localparam int ACC_W   = 64;

	// Fixed-point constants
	localparam logic [T_W-1:0]   T_ONE    = 17'd65536;
	localparam logic [POW_W-1:0] POW_ONE  = 31'h4000_0000;
	localparam logic [Q_W-1:0]   W_ONE    = 29'h1000_0000;
	localparam logic [ACC_W-1:0] ACC_RND  = 64'h0000_0000_0800_0000;
	localparam logic [DEG_W-1:0] DEG_RESET = 3'd2;

	// Item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	// Input item
	typedef struct packed {
		logic                      func;
		logic [2:0]                point_index;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [T_W-1:0]            t_value;
	} bcpe_item_t;

	// Result item
	typedef struct packed {
		logic signed [COORD_W-1:0] curve_x;
		logic signed [COORD_W-1:0] curve_y;
		logic                      saturated;
	} bcpe_result_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POW_T,
		ST_POW_U,
		ST_POW_END,
		ST_WQ,
		ST_WQ_WAIT,
		ST_WC,
		ST_WC_WAIT,
		ST_WX,
		ST_WY,
		ST_DRAIN,
		ST_DONE
	} bcpe_state_t;

	// Multiplier operations (also the writeback destination in the following cycle)
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TP_T,   // t power step
		OP_UP_U,   // (1-t) power step
		OP_TP_UP,  // t^i * (1-t)^(n-i)
		OP_C_Q,    // binomial coefficient times rounded product
		OP_W_X,    // weight times control x
		OP_W_Y     // weight times control y
	} bcpe_op_t;

	// Sequencer to datapath control
	typedef struct packed {
		logic             start;   // evaluate item transferred
		logic             load;    // load item transferred
		bcpe_op_t         op;
		logic [DEG_W-1:0] idx;     // power step k or point i
		logic [DEG_W-1:0] deg;     // effective degree n
		logic             finish;  // write result register
	} bcpe_ctrl_t;

	// Binomial coefficients C(n,k), n up to 7
	localparam logic [BIN_W-1:0] BINOM_TBL [8][8] = '{
		'{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
		'{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
		'{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
	};

	function automatic logic [BIN_W-1:0] binom_f(input logic [DEG_W-1:0] n,
		input logic [DEG_W-1:0] k);
		return BINOM_TBL[n][k];
	endfunction

endpackage

// ===== rtl/core/bcpe_mul.sv =====
// ----------------------------------------------------------------------------
// bcpe_mul
// Shared signed 33x33 multiplier with a registered product. Every product of
// the evaluation goes through this one unit.
// ----------------------------------------------------------------------------
module bcpe_mul
	import bcpe_pkg::*;
(
	input  logic                     clk,
	input  logic signed [OPND_W-1:0] a,
	input  logic signed [OPND_W-1:0] b,
	output logic signed [PROD_W-1:0] p_s1
);

	// product register
	always_ff @(posedge clk) begin
		p_s1 <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

// ===== rtl/core/bcpe_seq.sv =====
// ----------------------------------------------------------------------------
// bcpe_seq
// Sequencer: walks the power steps and then the per-point weight and
// accumulate steps, issuing one multiplier operation at a time.
// ----------------------------------------------------------------------------
module bcpe_seq
	import bcpe_pkg::*;
#(
	parameter int MAX_POINTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_func,
	input  logic [DEG_W-1:0] curve_degree,
	input  logic             out_free,
	output logic             item_stall,
	output bcpe_ctrl_t       ctrl
);

	bcpe_state_t      state_q, state_nxt;
	logic [DEG_W-1:0] k_q, i_q, n_q;
	logic [DEG_W-1:0] n_sat;
	logic             xfer;

	// degree clipped to the store size
	always_comb begin
		if (32'(curve_degree) > MAX_POINTS - 1) begin
			n_sat = DEG_W'(MAX_POINTS - 1);
		end else begin
			n_sat = curve_degree;
		end
	end

	assign xfer = (state_q == ST_IDLE) && item_valid;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (xfer && item_func == FUNC_EVAL) begin
					state_nxt = (n_sat == '0) ? ST_WQ : ST_POW_T;
				end
			end
			ST_POW_T:   state_nxt = ST_POW_U;
			ST_POW_U:   state_nxt = (k_q == n_q) ? ST_POW_END : ST_POW_T;
			ST_POW_END: state_nxt = ST_WQ;
			ST_WQ:      state_nxt = ST_WQ_WAIT;
			ST_WQ_WAIT: state_nxt = ST_WC;
			ST_WC:      state_nxt = ST_WC_WAIT;
			ST_WC_WAIT: state_nxt = ST_WX;
			ST_WX:      state_nxt = ST_WY;
			ST_WY:      state_nxt = (i_q == n_q) ? ST_DRAIN : ST_WQ;
			ST_DRAIN:   state_nxt = ST_DONE;
			ST_DONE:    state_nxt = out_free ? ST_IDLE : ST_DONE;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_stall  = (state_q != ST_IDLE);
		ctrl.start  = xfer && (item_func == FUNC_EVAL);
		ctrl.load   = xfer && (item_func == FUNC_LOAD);
		ctrl.deg    = n_q;
		ctrl.idx    = i_q;
		ctrl.finish = 1'b0;
		ctrl.op     = OP_NONE;
		unique case (state_q)
			ST_POW_T: begin
				ctrl.op  = OP_TP_T;
				ctrl.idx = k_q;
			end
			ST_POW_U: begin
				ctrl.op  = OP_UP_U;
				ctrl.idx = k_q;
			end
			ST_WQ:   ctrl.op = OP_TP_UP;
			ST_WC:   ctrl.op = OP_C_Q;
			ST_WX:   ctrl.op = OP_W_X;
			ST_WY:   ctrl.op = OP_W_Y;
			ST_DONE: ctrl.finish = out_free;
			default: ctrl.op = OP_NONE;
		endcase
	end

	// state and step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			i_q     <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (xfer && item_func == FUNC_EVAL) begin
				n_q <= n_sat;
				k_q <= DEG_W'(1);
				i_q <= '0;
			end
			if (state_q == ST_POW_U && k_q != n_q) begin
				k_q <= k_q + DEG_W'(1);
			end
			if (state_q == ST_WY && i_q != n_q) begin
				i_q <= i_q + DEG_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/bcpe_dp.sv =====
// ----------------------------------------------------------------------------
// bcpe_dp
// Datapath: control point store, power tables, weight registers,
// accumulators, the shared multiplier and the result register.
// ----------------------------------------------------------------------------
module bcpe_dp
	import bcpe_pkg::*;
#(
	parameter int MAX_POINTS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  bcpe_ctrl_t   ctrl,
	input  bcpe_item_t   item,
	input  logic         result_stall,
	output logic         result_valid,
	output bcpe_result_t result,
	output logic         out_free
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam logic signed [35:0] CLIP_HI = 36'sh0_7FFF_FFFF;
	localparam logic signed [35:0] CLIP_LO = 36'shF_8000_0000;

	logic signed [COORD_W-1:0] xs_q [MAX_POINTS];
	logic signed [COORD_W-1:0] ys_q [MAX_POINTS];
	logic [POW_W-1:0]          tp_q [MAX_POINTS];
	logic [POW_W-1:0]          up_q [MAX_POINTS];
	logic [T_W-1:0]            t_q, u_q, t_sat;
	logic [Q_W-1:0]            q_q, w_q;
	logic signed [ACC_W-1:0]   acc_x_q, acc_y_q;
	bcpe_op_t                  op_s1;
	logic [DEG_W-1:0]          idx_s1;
	logic                      result_valid_q;
	bcpe_result_t              result_q;

	logic [IDX_W-1:0]          tp_ra, up_ra, pt_ra, wb_a, ld_a;
	logic signed [OPND_W-1:0]  opa, opb;
	logic signed [PROD_W-1:0]  p_s1;
	logic [47:0]               tsum;
	logic [61:0]               qsum;
	logic [POW_W-1:0]          pow_new;
	logic [Q_W-1:0]            q_new, w_new;
	logic [32:0]               clip_x, clip_y;
	logic                      ld_hit;

	// clip a Q16.16 sum to 32 bits; msb is the clip flag
	function automatic logic [32:0] clip_f(input logic signed [35:0] v);
		if (v > CLIP_HI) begin
			return {1'b1, 32'h7FFF_FFFF};
		end else if (v < CLIP_LO) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, v[31:0]};
	endfunction

	// t clipped to one
	assign t_sat = (item.t_value > T_ONE) ? T_ONE : item.t_value;

	// read and write addresses
	assign ld_hit = 32'(item.point_index) < MAX_POINTS;
	assign ld_a   = IDX_W'(item.point_index);
	assign pt_ra  = IDX_W'(ctrl.idx);
	assign wb_a   = IDX_W'(idx_s1);
	assign tp_ra  = (ctrl.op == OP_TP_T) ? IDX_W'(ctrl.idx - DEG_W'(1))
	                                     : IDX_W'(ctrl.idx);
	assign up_ra  = (ctrl.op == OP_UP_U) ? IDX_W'(ctrl.idx - DEG_W'(1))
	                                     : IDX_W'(ctrl.deg - ctrl.idx);

	// operand select
	always_comb begin
		opa = '0;
		opb = '0;
		case (ctrl.op)
			OP_TP_T: begin
				opa = $signed({2'b00, tp_q[tp_ra]});
				opb = $signed({16'b0, t_q});
			end
			OP_UP_U: begin
				opa = $signed({2'b00, up_q[up_ra]});
				opb = $signed({16'b0, u_q});
			end
			OP_TP_UP: begin
				opa = $signed({2'b00, tp_q[tp_ra]});
				opb = $signed({2'b00, up_q[up_ra]});
			end
			OP_C_Q: begin
				opa = $signed({27'b0, binom_f(ctrl.deg, ctrl.idx)});
				opb = $signed({4'b0, q_q});
			end
			OP_W_X: begin
				opa = $signed({4'b0, w_q});
				opb = $signed({xs_q[pt_ra][COORD_W-1], xs_q[pt_ra]});
			end
			OP_W_Y: begin
				opa = $signed({4'b0, w_q});
				opb = $signed({ys_q[pt_ra][COORD_W-1], ys_q[pt_ra]});
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	bcpe_mul u_mul (
		.clk  (clk),
		.a    (opa),
		.b    (opb),
		.p_s1 (p_s1)
	);

	// product rounding and weight clamp
	assign tsum    = p_s1[47:0] + 48'h0000_0000_8000;
	assign pow_new = tsum[46:16];
	assign qsum    = p_s1[61:0] + 62'h0000_0000_8000_0000;
	assign q_new   = qsum[60:32];
	assign w_new   = (p_s1[34:0] > 35'(W_ONE)) ? W_ONE : p_s1[Q_W-1:0];

	// final rounding is folded into the accumulator start value
	assign clip_x = clip_f(acc_x_q[63:28]);
	assign clip_y = clip_f(acc_y_q[63:28]);

	// writeback tag follows the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else begin
			op_s1 <= ctrl.op;
		end
	end

	// store, tables and accumulators
	always_ff @(posedge clk) begin
		idx_s1 <= ctrl.idx;
		if (ctrl.load && ld_hit) begin
			xs_q[ld_a] <= item.point_x;
			ys_q[ld_a] <= item.point_y;
		end
		if (ctrl.start) begin
			t_q      <= t_sat;
			u_q      <= T_ONE - t_sat;
			tp_q[0]  <= POW_ONE;
			up_q[0]  <= POW_ONE;
			acc_x_q  <= $signed(ACC_RND);
			acc_y_q  <= $signed(ACC_RND);
		end
		case (op_s1)
			OP_TP_T:  tp_q[wb_a] <= pow_new;
			OP_UP_U:  up_q[wb_a] <= pow_new;
			OP_TP_UP: q_q        <= q_new;
			OP_C_Q:   w_q        <= w_new;
			OP_W_X:   acc_x_q    <= acc_x_q + p_s1[ACC_W-1:0];
			OP_W_Y:   acc_y_q    <= acc_y_q + p_s1[ACC_W-1:0];
			default:  ;
		endcase
		if (ctrl.finish) begin
			result_q.curve_x   <= clip_x[31:0];
			result_q.curve_y   <= clip_y[31:0];
			result_q.saturated <= clip_x[32] | clip_y[32];
		end
	end

	// result register valid
	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/core/bezier_curve_point_evaluator.sv =====
// Load item: the next item can follow in the next cycle.
// Evaluate item of degree n: power steps (none for degree zero), then for each
// point the weight and x and y steps; no new item is taken until the result is
// written. The single shared 33x33 multiplier and its writeback set the pace.
// Asynchronous active-low reset clears control and sets the degree to 2;
// the control point store holds nothing defined until loaded.
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator
// Bernstein-form Bezier evaluation over up to MAX_POINTS control points in
// signed Q16.16, with a degree register and saturating results.
// ----------------------------------------------------------------------------
module bezier_curve_point_evaluator
	import bcpe_pkg::*;
#(
	parameter int MAX_POINTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  bcpe_item_t       item,
	output logic             result_valid,
	input  logic             result_stall,
	output bcpe_result_t     result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [DEG_W-1:0] cfg_data
);

	logic [DEG_W-1:0] curve_degree_q;
	logic             out_free;
	bcpe_ctrl_t       ctrl;

	// degree register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_degree_q <= DEG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			curve_degree_q <= cfg_data;
		end
	end

	bcpe_seq #(
		.MAX_POINTS (MAX_POINTS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_func    (item.func),
		.curve_degree (curve_degree_q),
		.out_free     (out_free),
		.item_stall   (item_stall),
		.ctrl         (ctrl)
	);

	bcpe_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.out_free     (out_free)
	);

endmodule

// ===== rtl/core/bcpe_chk.sv =====
// ----------------------------------------------------------------------------
// bcpe_chk
// Port-level checks for the Bezier curve point evaluator, bound to the top.
// ----------------------------------------------------------------------------
module bcpe_chk
	import bcpe_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input bcpe_item_t       item,
	input logic             result_valid,
	input logic             result_stall,
	input bcpe_result_t     result
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// an evaluate transfer makes the block busy
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.func == FUNC_EVAL |=> item_stall)
		else $error("no busy after evaluate transfer");

	// a load transfer leaves the block free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.func == FUNC_LOAD |=> !item_stall)
		else $error("busy after load transfer");

	// a new result only comes out of an evaluation in progress
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result without evaluation");

endmodule

bind bezier_curve_point_evaluator bcpe_chk u_chk (.*);
